// ----- rtl/dsm_pkg.sv -----
// Shared types and constants for the substring matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsm_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int SYM_W           = 8;

	// operation codes carried on the input channel
	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	// control broadcast along the chain of cells
	typedef struct packed {
		logic text_en; // advance the partial-match bits by one text symbol
		logic clr;     // drop all partial matches
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/dsm_cell.sv -----
// One cell of the matcher chain: one pattern symbol and its prefix-match bit.
// Depends on dsm_pkg.
`default_nettype none

module dsm_cell
	import dsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire logic             wr_en,
	input  wire logic [SYM_W-1:0] sym_in,
	input  wire logic             match_in,
	output logic                  match_next,
	output logic                  match_q
);

	logic [SYM_W-1:0] sym_q;

	// prefix ending here matches if the shorter prefix matched one symbol ago
	assign match_next = match_in && (sym_q == sym_in);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_q <= sym_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clr) begin
			match_q <= 1'b0;
		end else if (ctl.text_en) begin
			match_q <= match_next;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dna_substring_matcher.sv -----
// Top level of the substring matcher: pattern control, chain of cells, result register.
// Depends on dsm_pkg and dsm_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation, symbol and last.
//   operation OP_PATTERN appends symbol to the pattern; last closes it, and the
//   next pattern beat starts a new pattern. operation OP_TEXT streams a text
//   symbol; a text beat closes any open pattern.
//   Output channel (out_valid/out_ready) carries found and pattern_overflow,
//   one beat for each text beat with last set, in the cycle after it is taken.
//   Throughput: one beat per cycle unless a held result stalls the input. Every
//   pattern position is a cell that compares its stored symbol with the text
//   symbol in the same cycle, so the whole prefix-match vector advances at once;
//   the hit test is an OR across the chain qualified by the pattern length.
//   Pattern symbols beyond MAX_PATTERN are dropped and flag pattern_overflow.
//   Stall: while a result is held and out_ready is low, in_ready is low.
//   Reset: pattern empty and closed, no partial matches, output empty. The
//   pattern store is not cleared; an empty pattern matches every text.
`default_nettype none

module dna_substring_matcher
	import dsm_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             operation,
	input  wire logic [SYM_W-1:0] symbol,
	input  wire logic             last,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  found,
	output logic                  pattern_overflow
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic             closed_q;
	logic             ovf_q;
	logic [LEN_W-1:0] len_q;
	logic             seen_q;
	logic             out_valid_q;
	logic             found_q;
	logic             ovf_out_q;

	logic             in_beat;
	logic             pat_beat;
	logic             text_beat;
	logic [LEN_W-1:0] wr_pos;
	logic             wr_room;
	cell_ctl_t        ctl;

	logic [MAX_PATTERN-1:0] wr_en;
	logic [MAX_PATTERN-1:0] tail;
	logic [MAX_PATTERN-1:0] m_q;
	logic [MAX_PATTERN-1:0] m_next;
	logic                   hit;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_beat   = in_valid && in_ready;
	assign pat_beat  = in_beat && (operation == OP_PATTERN);
	assign text_beat = in_beat && (operation == OP_TEXT);

	// a closed pattern restarts from position zero
	assign wr_pos  = closed_q ? '0 : len_q;
	assign wr_room = (wr_pos != LEN_W'(MAX_PATTERN));

	assign ctl.text_en = text_beat;
	assign ctl.clr     = (pat_beat && closed_q) || (text_beat && last);

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		assign wr_en[i] = pat_beat && wr_room && (wr_pos == LEN_W'(i));
		assign tail[i]  = (len_q == LEN_W'(i + 1));

		dsm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.wr_en      (wr_en[i]),
			.sym_in     (symbol),
			.match_in   ((i == 0) ? 1'b1 : m_q[(i == 0) ? 0 : i - 1]),
			.match_next (m_next[i]),
			.match_q    (m_q[i])
		);
	end

	// whole pattern ends at this symbol; an empty pattern always hits
	assign hit = (len_q == '0) || (|(m_next & tail));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b1;
			ovf_q    <= 1'b0;
			len_q    <= '0;
			seen_q   <= 1'b0;
		end else if (pat_beat) begin
			closed_q <= last;
			if (wr_room) begin
				len_q <= wr_pos + LEN_W'(1);
				ovf_q <= closed_q ? 1'b0 : ovf_q;
			end else begin
				len_q <= wr_pos;
				ovf_q <= 1'b1;
			end
			if (closed_q) begin
				seen_q <= 1'b0;
			end
		end else if (text_beat) begin
			closed_q <= 1'b1;
			seen_q   <= last ? 1'b0 : (seen_q || hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (text_beat && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_beat && last) begin
			found_q   <= (seen_q || hit) && !ovf_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = found_q;
	assign pattern_overflow = ovf_out_q;

endmodule

`default_nettype wire

// ----- rtl/dsm_checker.sv -----
// Port-level checks for the substring matcher, bound to the top level.
// Depends on dsm_pkg and dna_substring_matcher.
`default_nettype none

module dsm_checker
	import dsm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             operation,
	input wire logic             last,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             found,
	input wire logic             pattern_overflow
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(pattern_overflow))
		else $error("result beat changed while stalled");

	a_found_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && pattern_overflow))
		else $error("found reported with pattern overflow");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_TEXT) && last |=> out_valid)
		else $error("last text beat produced no result");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready && (operation == OP_TEXT) && last)
		|=> !out_valid)
		else $error("result without last text beat");

endmodule

bind dna_substring_matcher dsm_checker u_dsm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.operation        (operation),
	.last             (last),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.found            (found),
	.pattern_overflow (pattern_overflow)
);

`default_nettype wire
